### hw/rtl/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher core.
// No dependencies; imported by every other file in hw/rtl.
`timescale 1ns / 1ps

package rc4_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned KEY_SLOTS  = 16;
  localparam int unsigned KSEL_W     = 4;
  localparam int unsigned KLEN_W     = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_KEY_LOW  = 2'd0;
  localparam cfg_idx_t CFG_KEY_HIGH = 2'd1;
  localparam cfg_idx_t CFG_KEY_LEN  = 2'd2;

  localparam logic [KLEN_W-1:0] KEY_LEN_RESET = 5'd8;

  // One write and one read per cycle into the permutation store
  typedef struct packed {
    logic  we;
    byte_t waddr;
    byte_t wdata;
    byte_t raddr;
  } sbox_req_t;

endpackage

### hw/rtl/rc4_sbox.sv
// 256 x 8 permutation store: one write port, one read port, registered read data.
// Depends on rc4_pkg.
`timescale 1ns / 1ps

module rc4_sbox (
  input  logic              clk,
  input  rc4_pkg::sbox_req_t req,
  output rc4_pkg::byte_t    rdata
);
  import rc4_pkg::*;

  byte_t mem [PERM_DEPTH];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/rc4_ctrl.sv
// Sequencer for key schedule and keystream generation around one shared 8-bit adder.
// Depends on rc4_pkg; drives the rc4_sbox request port.
`timescale 1ns / 1ps

module rc4_ctrl #(
  parameter int unsigned KEY_MAX_BYTES = 16,
  localparam int unsigned KW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rc4_pkg::byte_t              in_data_byte,
  input  logic                        in_starts_message,
  input  rc4_pkg::byte_t              key_byte,
  input  logic [rc4_pkg::KLEN_W-1:0]  key_len,
  output logic [KW-1:0]               key_idx,
  output rc4_pkg::sbox_req_t          mem_req,
  input  rc4_pkg::byte_t              mem_rdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rc4_pkg::byte_t              out_byte
);
  import rc4_pkg::*;

  typedef enum logic [3:0] {
    IDLE, INIT, K_RD_N, K_RD_J, K_WR_N, K_WR_J,
    G_RD_I, G_RD_J, G_WR_I, G_WR_J, G_RD_T, G_OUT
  } state_t;

  state_t        state_r;
  byte_t         n_r, i_r, j_r, si_r, sj_r, t_r, data_r, out_byte_r;
  logic [KW-1:0] k_r;
  logic          out_valid_r;

  // shared adder
  byte_t add_a, add_b, add_c, sum;

  always_comb begin
    add_a = '0;
    add_b = '0;
    add_c = '0;
    unique case (state_r)
      K_RD_J: begin add_a = j_r;  add_b = mem_rdata; add_c = key_byte; end
      G_RD_I: begin add_a = i_r;  add_b = 8'd1; end
      G_RD_J: begin add_a = j_r;  add_b = mem_rdata; end
      G_WR_J: begin add_a = si_r; add_b = sj_r; end
      default: ;
    endcase
  end

  assign sum = add_a + add_b + add_c;

  always_comb begin
    mem_req = '0;
    unique case (state_r)
      INIT:   begin mem_req.we = 1'b1; mem_req.waddr = n_r; mem_req.wdata = n_r; end
      K_RD_N: mem_req.raddr = n_r;
      K_RD_J: mem_req.raddr = sum;
      K_WR_N: begin mem_req.we = 1'b1; mem_req.waddr = n_r; mem_req.wdata = mem_rdata; end
      K_WR_J: begin mem_req.we = 1'b1; mem_req.waddr = j_r; mem_req.wdata = si_r; end
      G_RD_I: mem_req.raddr = sum;
      G_RD_J: mem_req.raddr = sum;
      G_WR_I: begin mem_req.we = 1'b1; mem_req.waddr = i_r; mem_req.wdata = mem_rdata; end
      G_WR_J: begin mem_req.we = 1'b1; mem_req.waddr = j_r; mem_req.wdata = si_r; end
      G_RD_T: mem_req.raddr = t_r;
      G_OUT:  mem_req.raddr = t_r;   // hold read data while the output stalls
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      i_r         <= '0;
      j_r         <= '0;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // G_OUT handles its own valid update
      if (out_valid_r && out_ready && state_r != G_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_valid) begin
            data_r <= in_data_byte;
            if (in_starts_message) begin
              n_r     <= '0;
              state_r <= INIT;
            end else begin
              state_r <= G_RD_I;
            end
          end
        end
        INIT: begin
          n_r <= n_r + 8'd1;
          if (n_r == 8'hFF) begin
            k_r     <= '0;
            j_r     <= '0;
            state_r <= K_RD_N;
          end
        end
        K_RD_N: state_r <= K_RD_J;
        K_RD_J: begin
          si_r    <= mem_rdata;
          j_r     <= sum;
          state_r <= K_WR_N;
        end
        K_WR_N: state_r <= K_WR_J;
        K_WR_J: begin
          n_r <= n_r + 8'd1;
          if ((KLEN_W'(k_r) + 5'd1) >= key_len) begin
            k_r <= '0;
          end else begin
            k_r <= k_r + 1'b1;
          end
          if (n_r == 8'hFF) begin
            i_r     <= '0;
            j_r     <= '0;
            state_r <= G_RD_I;
          end else begin
            state_r <= K_RD_N;
          end
        end
        G_RD_I: begin
          i_r     <= sum;
          state_r <= G_RD_J;
        end
        G_RD_J: begin
          si_r    <= mem_rdata;
          j_r     <= sum;
          state_r <= G_WR_I;
        end
        G_WR_I: begin
          sj_r    <= mem_rdata;
          state_r <= G_WR_J;
        end
        G_WR_J: begin
          t_r     <= sum;
          state_r <= G_RD_T;
        end
        G_RD_T: state_r <= G_OUT;
        G_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_byte_r  <= data_r ^ mem_rdata;
            out_valid_r <= 1'b1;
            state_r     <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == IDLE);
  assign key_idx   = k_r;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  // output index is the sum of the two swapped entries
  a_tidx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == G_RD_T) |-> (t_r == 8'(si_r + sj_r)))
    else $error("keystream index mismatch");

  // key schedule hands over with both indices cleared
  a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == G_RD_I && $past(state_r) == K_WR_J) |-> (i_r == 8'd0 && j_r == 8'd0))
    else $error("indices not cleared after key schedule");

  // key byte pointer stays inside the active key length
  a_kidx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == K_RD_J) |-> (KLEN_W'(k_r) < key_len))
    else $error("key index out of range");

  // a finished byte is never dropped over a pending one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_byte_r)))
    else $error("pending output overwritten");

endmodule

### hw/rtl/rc4_stream_cipher_core.sv
// Top level of the RC4 stream cipher core: configuration registers, key byte select,
// sequencer and permutation store. Depends on rc4_pkg, rc4_sbox and rc4_ctrl.
`timescale 1ns / 1ps

// RC4 stream cipher core.
//
// Input channel (in_valid/in_ready): one word per message byte. in_data_byte is
// XORed with the next keystream byte. With in_starts_message set, the key
// schedule runs first over the configured key and both indices return to zero.
// Output channel (out_valid/out_ready): one word, out_byte, per input word.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 loads key
// bytes 0-7, index 1 key bytes 8-15, index 2 the key length (1..16; 0 acts as 1,
// larger values saturate to KEY_MAX_BYTES). Other indexes are ignored.
//
// Datapath: the i, j and t index sums run through one shared 8-bit adder and a
// single-read, single-write permutation RAM. A plain byte steps through a read of
// S[i], a read of S[j], the two swap writes and a read of S[t] before out_valid,
// and the next byte is taken once the sequencer is back in idle after that result
// is loaded. A message start first fills the permutation with the identity, then
// runs one key schedule step per entry (read S[n], read S[j], two swap writes),
// its pace set by the RAM port count. The input is not ready while a byte is in work.
// Reset clears the sequencer, indices and output valid; the key length goes to 8.
// The permutation is undefined until the first message start.
// A stalled receiver holds the finished word in the output register; the core
// finishes the next byte and waits at the end until the register frees.

module rc4_stream_cipher_core #(
  parameter int unsigned KEY_MAX_BYTES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rc4_pkg::byte_t                   in_data_byte,
  input  logic                             in_starts_message,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rc4_pkg::byte_t                   out_byte,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  rc4_pkg::cfg_idx_t                cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rc4_pkg::*;

  localparam int unsigned KW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

  logic [CFG_DATA_W-1:0] key_low_r, key_high_r;
  logic [KLEN_W-1:0]     key_length_r;
  logic [KLEN_W-1:0]     key_len_eff;
  byte_t                 key_arr [KEY_SLOTS];
  logic [KW-1:0]         key_idx;
  byte_t                 key_byte;
  sbox_req_t             mem_req;
  byte_t                 mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r    <= '0;
      key_high_r   <= '0;
      key_length_r <= KEY_LEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_low_r    <= cfg_data;
        CFG_KEY_HIGH: key_high_r   <= cfg_data;
        CFG_KEY_LEN:  key_length_r <= cfg_data[KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero length acts as one byte; long keys clip to the supported maximum
  always_comb begin
    priority if (key_length_r == '0) begin
      key_len_eff = KLEN_W'(1);
    end else if (key_length_r > KLEN_W'(KEY_MAX_BYTES)) begin
      key_len_eff = KLEN_W'(KEY_MAX_BYTES);
    end else begin
      key_len_eff = key_length_r;
    end
  end

  for (genvar b = 0; b < KEY_SLOTS / 2; b++) begin : g_key
    assign key_arr[b]                 = key_low_r[b*8 +: 8];
    assign key_arr[b + KEY_SLOTS / 2] = key_high_r[b*8 +: 8];
  end

  assign key_byte = key_arr[KSEL_W'(key_idx)];

  rc4_ctrl #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_starts_message (in_starts_message),
    .key_byte          (key_byte),
    .key_len           (key_len_eff),
    .key_idx           (key_idx),
    .mem_req           (mem_req),
    .mem_rdata         (mem_rdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte)
  );

  rc4_sbox u_sbox (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
